@@ design/canonical_huffman_decoder_defines.svh @@
// Assertion macros used by the decoder datapath.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef CANONICAL_HUFFMAN_DECODER_DEFINES_SVH
`define CANONICAL_HUFFMAN_DECODER_DEFINES_SVH

// check a property on every clock outside reset
`define CHD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never holds
`define CHD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/chd_pkg.sv @@
// Shared constants, codes and types of the canonical Huffman decoder.
// No dependencies.
package chd_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_LEN      = 15;
    localparam int SYM_W        = 8;
    localparam int LEN_W        = 4;
    localparam int LEN_SLOTS    = 16;
    localparam int CNT_W        = 9;
    localparam int CODE_W       = 24;
    localparam int ACC_W        = 16;
    localparam int BITS_W       = 5;
    localparam int TARGET_W     = 32;
    localparam int STATUS_W     = 3;
    localparam int SWEEP_W      = 9;
    localparam int BITCNT_W     = 3;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_BYTE   = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_SYMBOL   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CODE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_FIRST,
        S_SORT,
        S_BIT,
        S_READ,
        S_RESULT,
        S_FLUSH
    } chd_state_t;

    typedef struct packed {
        logic accept;
        logic count_step;
        logic first_step;
        logic sort_step;
        logic bit_step;
        logic take_read;
        logic push;
        logic flush;
    } chd_cmd_t;

    typedef struct packed {
        logic sweep_end;
        logic first_end;
        logic done_reached;
        logic err_set;
        logic bit_over;
        logic bit_match;
        logic bit_last;
        logic out_blocked;
    } chd_status_t;

endpackage

@@ design/chd_item_if.sv @@
// Input channel of the decoder: valid/ready plus one command beat.
// Depends on chd_pkg.
interface chd_item_if
    import chd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic [SYM_W-1:0]    symbol_index;
    logic [LEN_W-1:0]    code_length;
    logic [SYM_W-1:0]    data_byte;

    modport source (output valid, opcode, symbol_index, code_length, data_byte, input ready);
    modport sink   (input valid, opcode, symbol_index, code_length, data_byte, output ready);
endinterface

@@ design/chd_result_if.sv @@
// Output channel of the decoder: valid/ready plus one result beat.
// Depends on chd_pkg.
interface chd_result_if
    import chd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SYM_W-1:0]    decoded_symbol;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, decoded_symbol, status, last, input ready);
    modport sink   (input valid, decoded_symbol, status, last, output ready);
endinterface

@@ design/chd_datapath.sv @@
// Tables, memories, bit-serial decode registers and result staging.
// Depends on chd_pkg and canonical_huffman_decoder_defines.svh.
`include "canonical_huffman_decoder_defines.svh"

module chd_datapath
    import chd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  chd_cmd_t            cmd,
    output chd_status_t         stat,
    input  logic [1:0]          opcode,
    input  logic [SYM_W-1:0]    symbol_index,
    input  logic [LEN_W-1:0]    code_length,
    input  logic [SYM_W-1:0]    data_byte,
    input  logic                cfg_wen,
    input  logic [TARGET_W-1:0] cfg_wdata,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SYM_W-1:0]    out_symbol,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_last
);

    logic [LEN_W-1:0]    len_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] len_valid_reg;
    logic [LEN_W-1:0]    len_q;
    logic                lv_q;
    logic [SYM_W-1:0]    sorted_mem [SYMBOL_COUNT];
    logic [SYM_W-1:0]    sorted_q;

    logic [CNT_W-1:0]    counts_reg [LEN_SLOTS];
    logic [CODE_W-1:0]   fc_reg     [LEN_SLOTS];
    logic [CNT_W-1:0]    fi_reg     [LEN_SLOTS];
    logic [CNT_W-1:0]    np_reg     [LEN_SLOTS];

    logic [TARGET_W-1:0] target_reg;
    logic [SWEEP_W-1:0]  sweep_reg;
    logic [LEN_W-1:0]    lstep_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [BITS_W-1:0]   bits_reg;
    logic [TARGET_W-1:0] done_reg;
    logic [STATUS_W-1:0] err_reg;
    logic [SYM_W-1:0]    byte_reg;
    logic [BITCNT_W-1:0] bitcnt_reg;
    logic [SYM_W-1:0]    stage_sym_reg;
    logic [STATUS_W-1:0] stage_status_reg;
    logic                pend_valid_reg;
    logic [SYM_W-1:0]    pend_sym_reg;
    logic [STATUS_W-1:0] pend_status_reg;
    logic                out_valid_reg;
    logic [SYM_W-1:0]    out_sym_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    logic [ACC_W-1:0]    acc_next;
    logic [BITS_W-1:0]   bits_next;
    logic [LEN_W-1:0]    bit_len;
    logic [CODE_W-1:0]   acc_ext;
    logic [CODE_W-1:0]   offset;
    logic [SYM_W-1:0]    bit_pos;
    logic                bit_over;
    logic                bit_match;
    logic                sweep_hit;
    logic [SYM_W-1:0]    sweep_sym;
    logic [CODE_W-1:0]   code_sum;
    logic [CODE_W-1:0]   code_next;
    logic                out_load;

    assign acc_next  = {acc_reg[ACC_W-2:0], byte_reg[SYM_W-1]};
    assign bits_next = bits_reg + BITS_W'(1);
    assign bit_len   = bits_next[LEN_W-1:0];
    assign bit_over  = (bits_next > BITS_W'(MAX_LEN));
    assign acc_ext   = CODE_W'(acc_next);
    assign offset    = acc_ext - fc_reg[bit_len];
    assign bit_match = !bit_over && (acc_ext >= fc_reg[bit_len])
                       && (offset < CODE_W'(counts_reg[bit_len]));
    assign bit_pos   = fi_reg[bit_len][SYM_W-1:0] + offset[SYM_W-1:0];

    assign sweep_hit = (sweep_reg != '0) && lv_q && (len_q != '0);
    assign sweep_sym = sweep_reg[SYM_W-1:0] - SYM_W'(1);
    assign code_sum  = code_reg + CODE_W'(counts_reg[lstep_reg - LEN_W'(1)]);
    assign code_next = {code_sum[CODE_W-2:0], 1'b0};

    assign out_load  = (cmd.push || cmd.flush) && pend_valid_reg;

    assign stat.sweep_end    = (sweep_reg == SWEEP_W'(SYMBOL_COUNT));
    assign stat.first_end    = (lstep_reg == LEN_W'(MAX_LEN));
    assign stat.done_reached = (done_reg >= target_reg);
    assign stat.err_set      = (err_reg != ST_SYMBOL);
    assign stat.bit_over     = bit_over;
    assign stat.bit_match    = bit_match;
    assign stat.bit_last     = (bitcnt_reg == '0);
    assign stat.out_blocked  = pend_valid_reg && out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_sym_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && opcode == OP_LOAD)
        begin
            len_mem[symbol_index] <= (code_length > LEN_W'(MAX_LEN)) ? '0 : code_length;
        end
        len_q <= len_mem[sweep_reg[SYM_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_valid_reg <= '0;
            lv_q          <= 1'b0;
        end
        else
        begin
            if (cmd.accept && opcode == OP_LOAD)
            begin
                len_valid_reg[symbol_index] <= 1'b1;
            end
            lv_q <= len_valid_reg[sweep_reg[SYM_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_step && sweep_hit)
        begin
            sorted_mem[np_reg[len_q][SYM_W-1:0]] <= sweep_sym;
        end
        sorted_q <= sorted_mem[bit_pos];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEN_SLOTS; i++)
            begin
                counts_reg[i] <= '0;
                fc_reg[i]     <= '0;
                fi_reg[i]     <= '0;
                np_reg[i]     <= '0;
            end
            target_reg       <= '0;
            sweep_reg        <= '0;
            lstep_reg        <= '0;
            code_reg         <= '0;
            idx_reg          <= '0;
            acc_reg          <= '0;
            bits_reg         <= '0;
            done_reg         <= '0;
            err_reg          <= ST_SYMBOL;
            byte_reg         <= '0;
            bitcnt_reg       <= '0;
            stage_sym_reg    <= '0;
            stage_status_reg <= ST_SYMBOL;
            pend_valid_reg   <= 1'b0;
            pend_sym_reg     <= '0;
            pend_status_reg  <= ST_SYMBOL;
            out_valid_reg    <= 1'b0;
            out_sym_reg      <= '0;
            out_status_reg   <= ST_SYMBOL;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                target_reg <= cfg_wdata;
            end

            if (cmd.accept)
            begin
                case (opcode)
                    OP_FINISH:
                    begin
                        for (int i = 0; i < LEN_SLOTS; i++)
                        begin
                            counts_reg[i] <= '0;
                        end
                        sweep_reg <= '0;
                        acc_reg   <= '0;
                        bits_reg  <= '0;
                        done_reg  <= '0;
                        err_reg   <= ST_SYMBOL;
                    end
                    OP_END:
                    begin
                        stage_sym_reg <= '0;
                        if (err_reg != ST_SYMBOL)
                        begin
                            stage_status_reg <= err_reg;
                        end
                        else if (done_reg >= target_reg)
                        begin
                            stage_status_reg <= ST_DONE;
                        end
                        else
                        begin
                            stage_status_reg <= ST_TRUNC;
                            err_reg          <= ST_TRUNC;
                        end
                    end
                    OP_BYTE:
                    begin
                        if (err_reg == ST_SYMBOL)
                        begin
                            if (done_reg >= target_reg)
                            begin
                                err_reg          <= ST_BAD_LEN;
                                stage_sym_reg    <= '0;
                                stage_status_reg <= ST_BAD_LEN;
                            end
                            else
                            begin
                                byte_reg   <= data_byte;
                                bitcnt_reg <= '1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // table build: count, first codes, placement
            if (cmd.count_step)
            begin
                if (sweep_hit)
                begin
                    counts_reg[len_q] <= counts_reg[len_q] + CNT_W'(1);
                end
                if (stat.sweep_end)
                begin
                    sweep_reg <= '0;
                    lstep_reg <= LEN_W'(1);
                    code_reg  <= '0;
                    idx_reg   <= '0;
                end
                else
                begin
                    sweep_reg <= sweep_reg + SWEEP_W'(1);
                end
            end

            if (cmd.first_step)
            begin
                fc_reg[lstep_reg] <= code_next;
                fi_reg[lstep_reg] <= idx_reg;
                np_reg[lstep_reg] <= idx_reg;
                code_reg          <= code_next;
                idx_reg           <= idx_reg + counts_reg[lstep_reg];
                lstep_reg         <= lstep_reg + LEN_W'(1);
            end

            if (cmd.sort_step)
            begin
                if (sweep_hit)
                begin
                    np_reg[len_q] <= np_reg[len_q] + CNT_W'(1);
                end
                sweep_reg <= stat.sweep_end ? '0 : sweep_reg + SWEEP_W'(1);
            end

            // one payload bit
            if (cmd.bit_step)
            begin
                byte_reg   <= {byte_reg[SYM_W-2:0], 1'b0};
                bitcnt_reg <= bitcnt_reg - BITCNT_W'(1);
                if (bit_match)
                begin
                    acc_reg  <= '0;
                    bits_reg <= '0;
                    done_reg <= done_reg + TARGET_W'(1);
                end
                else
                begin
                    acc_reg  <= acc_next;
                    bits_reg <= bits_next;
                end
                if (bit_over)
                begin
                    err_reg          <= ST_BAD_CODE;
                    stage_sym_reg    <= '0;
                    stage_status_reg <= ST_BAD_CODE;
                end
            end

            if (cmd.take_read)
            begin
                stage_sym_reg    <= sorted_q;
                stage_status_reg <= ST_SYMBOL;
            end

            // hold one result back so the final beat of an item carries last
            if (cmd.push)
            begin
                pend_valid_reg  <= 1'b1;
                pend_sym_reg    <= stage_sym_reg;
                pend_status_reg <= stage_status_reg;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_sym_reg    <= pend_sym_reg;
                out_status_reg <= pend_status_reg;
                out_last_reg   <= cmd.flush;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `CHD_NEVER(a_bits_bound, bits_reg > BITS_W'(MAX_LEN + 1), "code length counter overran")
    `CHD_ASSERT(a_push_pend, cmd.push |=> pend_valid_reg, "pushed result not held")
    `CHD_NEVER(a_err_sym, pend_valid_reg && pend_status_reg != ST_SYMBOL && pend_sym_reg != '0,
               "error result carries a symbol")
    `CHD_NEVER(a_load_lost, out_load && out_valid_reg && !out_ready,
               "result overwrote a waiting beat")

endmodule

@@ design/chd_ctrl.sv @@
// Sequencer of the decoder: build sweeps, bit loop and result hand-off.
// Depends on chd_pkg.
module chd_ctrl
    import chd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic [1:0]  opcode,
    output logic        item_ready,
    input  chd_status_t stat,
    output chd_cmd_t    cmd
);

    chd_state_t state_reg;
    chd_state_t state_next;
    logic       flush_after_reg;
    logic       flush_after_next;
    logic       accept;

    assign accept = item_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        flush_after_next = flush_after_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_FINISH:
                        begin
                            state_next = S_COUNT;
                        end
                        OP_END:
                        begin
                            state_next       = S_RESULT;
                            flush_after_next = 1'b1;
                        end
                        OP_BYTE:
                        begin
                            if (stat.err_set)
                            begin
                                state_next = S_IDLE;
                            end
                            else if (stat.done_reached)
                            begin
                                state_next       = S_RESULT;
                                flush_after_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_BIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_COUNT:
            begin
                if (stat.sweep_end)
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (stat.first_end)
                begin
                    state_next = S_SORT;
                end
            end
            S_SORT:
            begin
                if (stat.sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BIT:
            begin
                if (stat.done_reached)
                begin
                    state_next = S_FLUSH;
                end
                else if (stat.bit_over)
                begin
                    state_next       = S_RESULT;
                    flush_after_next = 1'b1;
                end
                else if (stat.bit_match)
                begin
                    state_next       = S_READ;
                    flush_after_next = stat.bit_last;
                end
                else if (stat.bit_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_READ:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!stat.out_blocked)
                begin
                    state_next = flush_after_reg ? S_FLUSH : S_BIT;
                end
            end
            S_FLUSH:
            begin
                if (!stat.out_blocked)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready     = (state_reg == S_IDLE);
        cmd            = '0;
        cmd.accept     = accept;
        cmd.count_step = (state_reg == S_COUNT);
        cmd.first_step = (state_reg == S_FIRST);
        cmd.sort_step  = (state_reg == S_SORT);
        cmd.bit_step   = (state_reg == S_BIT) && !stat.done_reached;
        cmd.take_read  = (state_reg == S_READ);
        cmd.push       = (state_reg == S_RESULT) && !stat.out_blocked;
        cmd.flush      = (state_reg == S_FLUSH) && !stat.out_blocked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            flush_after_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            flush_after_reg <= flush_after_next;
        end
    end

endmodule

@@ design/canonical_huffman_decoder.sv @@
// Canonical Huffman decoder top level: controller plus datapath.
// Depends on chd_pkg, chd_item_if, chd_result_if, chd_ctrl, chd_datapath.
//
//   port    | dir  | beat
//   item    | sink | opcode, symbol_index, code_length, data_byte
//   result  | src  | decoded_symbol, status, last
//   cfg     | in   | cfg_wen, cfg_wdata (symbol_target)
//
// Load: writes the length memory. Finish: two sweeps of the length memory (counting,
// then placement) around 15 first-code steps. Payload byte: accept, one step per bit,
// a sorted-table read and a result stage per decoded symbol, then a step to close the beat.
// No clearing pass after reset; the length memory uses per-entry valid bits.
// A full result register stalls the sequencer in its result states only.
module canonical_huffman_decoder
    import chd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    chd_item_if.sink            item,
    chd_result_if.source        result,
    input  logic                cfg_wen,
    input  logic [TARGET_W-1:0] cfg_wdata
);

    chd_cmd_t    cmd;
    chd_status_t stat;

    chd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .opcode     (item.opcode),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    chd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (item.opcode),
        .symbol_index (item.symbol_index),
        .code_length  (item.code_length),
        .data_byte    (item.data_byte),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_symbol   (result.decoded_symbol),
        .out_status   (result.status),
        .out_last     (result.last)
    );

endmodule

@@ tb/sv/canonical_huffman_decoder_test.sv @@
// Self-checking testbench for canonical_huffman_decoder: drives command beats,
// predicts the result beats with a built-in decoder model and compares them.
// Depends on chd_pkg, chd_item_if, chd_result_if and the decoder RTL.
module canonical_huffman_decoder_test;
    import chd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BUILD_WAIT  = 700;
    localparam int ITEM_GOAL   = 400;

    typedef struct {
        logic [SYM_W-1:0]    sym;
        logic [STATUS_W-1:0] status;
        logic                last;
    } symbol_beat_t;

    class decode_scoreboard;
        logic [LEN_W-1:0]    lengths[SYMBOL_COUNT];
        int unsigned         len_count[LEN_SLOTS];
        int unsigned         first_code[LEN_SLOTS];
        int unsigned         first_pos[LEN_SLOTS];
        logic [SYM_W-1:0]    by_length[SYMBOL_COUNT];
        logic [ACC_W-1:0]    acc;
        int unsigned         acc_bits;
        logic [TARGET_W-1:0] decoded;
        logic [TARGET_W-1:0] target;
        logic [STATUS_W-1:0] sticky;
        symbol_beat_t        pending[$];
        int                  errors;

        function void clear();
            foreach (lengths[i]) lengths[i] = '0;
            foreach (len_count[i])
            begin
                len_count[i] = 0;
                first_code[i] = 0;
                first_pos[i] = 0;
            end
            foreach (by_length[i]) by_length[i] = '0;
            acc = '0;
            acc_bits = 0;
            decoded = '0;
            target = '0;
            sticky = ST_SYMBOL;
            errors = 0;
        endfunction

        function void rebuild();
            int unsigned code;
            int unsigned pos;
            int unsigned slot[LEN_SLOTS];
            foreach (len_count[i]) len_count[i] = 0;
            for (int s = 0; s < SYMBOL_COUNT; s++)
                if (lengths[s] != 0) len_count[lengths[s]]++;
            code = 0;
            pos = 0;
            slot[0] = 0;
            first_code[0] = 0;
            first_pos[0] = 0;
            for (int l = 1; l <= MAX_LEN; l++)
            begin
                code = ((code + len_count[l-1]) << 1) & 32'hFF_FFFF;
                first_code[l] = code;
                first_pos[l] = pos;
                slot[l] = pos;
                pos += len_count[l];
            end
            for (int s = 0; s < SYMBOL_COUNT; s++)
                if (lengths[s] != 0)
                begin
                    by_length[slot[lengths[s]] & 8'hFF] = s[7:0];
                    slot[lengths[s]]++;
                end
            acc = '0;
            acc_bits = 0;
            decoded = '0;
            sticky = ST_SYMBOL;
        endfunction

        function void push(logic [SYM_W-1:0] sym, logic [STATUS_W-1:0] st, logic last);
            symbol_beat_t b;
            b.sym = sym;
            b.status = st;
            b.last = last;
            pending.insert(pending.size(), b);
        endfunction

        function void note_item(logic [1:0] op, logic [SYM_W-1:0] idx,
                                logic [LEN_W-1:0] len, logic [SYM_W-1:0] data);
            int n;
            int unsigned off;
            int unsigned l;
            n = 0;
            case (op)
                OP_LOAD: lengths[idx] = len;
                OP_FINISH: rebuild();
                OP_END:
                begin
                    if (sticky == ST_SYMBOL)
                        sticky = (decoded >= target) ? ST_SYMBOL : ST_TRUNC;
                    push(8'h00, (sticky == ST_SYMBOL) ? ST_DONE : sticky, 1'b1);
                end
                default:
                begin
                    if (sticky != ST_SYMBOL)
                        return;
                    if (decoded >= target)
                    begin
                        sticky = ST_BAD_LEN;
                        push(8'h00, ST_BAD_LEN, 1'b1);
                        return;
                    end
                    for (int b = 7; b >= 0; b--)
                    begin
                        if (decoded >= target)
                            break;
                        acc = {acc[ACC_W-2:0], data[b]};
                        acc_bits++;
                        l = acc_bits;
                        if (l > MAX_LEN)
                        begin
                            sticky = ST_BAD_CODE;
                            push(8'h00, ST_BAD_CODE, 1'b0);
                            n++;
                            break;
                        end
                        if (acc >= first_code[l])
                        begin
                            off = acc - first_code[l];
                            if (off < len_count[l])
                            begin
                                push(by_length[(first_pos[l] + off) & 8'hFF], ST_SYMBOL, 1'b0);
                                n++;
                                decoded++;
                                acc = '0;
                                acc_bits = 0;
                            end
                        end
                    end
                    if (n > 0)
                        pending[$].last = 1'b1;
                end
            endcase
        endfunction

        function void check(logic [SYM_W-1:0] sym, logic [STATUS_W-1:0] st, logic last);
            symbol_beat_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat sym=%0h status=%0d last=%0b", $realtime,
                         sym, st, last);
                return;
            end
            e = pending.pop_front();
            if (e.sym !== sym || e.status !== st || e.last !== last)
            begin
                errors++;
                $display("%0t: expected sym/status/last=%0h/%0d/%0b, got %0h/%0d/%0b",
                         $realtime, e.sym, e.status, e.last, sym, st, last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wen = 1'b0;
    logic [TARGET_W-1:0] cfg_wdata = '0;

    chd_item_if   item_bus();
    chd_result_if beat_bus();

    canonical_huffman_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (beat_bus),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    decode_scoreboard sb = new();
    int  items_sent = 0;
    int  cycle_count = 0;
    int  hold_cycles = 0;
    bit  calm = 1'b0;
    logic [LEN_W-1:0] cur_len[SYMBOL_COUNT];

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** canonical_huffman_decoder: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && beat_bus.valid && beat_bus.ready)
            sb.check(beat_bus.decoded_symbol, beat_bus.status, beat_bus.last);

    initial
    begin
        int stall_left;
        stall_left = 0;
        beat_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                beat_bus.ready = 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                beat_bus.ready = 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                beat_bus.ready = 1'b0;
                stall_left = $urandom_range(0, 5);
            end
            else
                beat_bus.ready = 1'b1;
        end
    end

    task automatic send(logic [1:0] op, logic [SYM_W-1:0] idx, logic [LEN_W-1:0] len,
                        logic [SYM_W-1:0] data);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            item_bus.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        item_bus.valid = 1'b1;
        item_bus.opcode = op;
        item_bus.symbol_index = idx;
        item_bus.code_length = len;
        item_bus.data_byte = data;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
        sb.note_item(op, idx, len, data);
        if (op == OP_LOAD)
            cur_len[idx] = len;
        items_sent++;
        @(negedge clk);
        item_bus.valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (BUILD_WAIT) @(posedge clk);
    endtask

    task automatic set_target(logic [TARGET_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_wen = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_wen = 1'b0;
        sb.target = v;
    endtask

    task automatic random_phase();
        int leaves[$];
        int syms[$];
        int pick;
        int l;
        int nsym;
        int mode;
        int unsigned next_code[LEN_SLOTS];
        int unsigned cnt[LEN_SLOTS];
        int unsigned codes[SYMBOL_COUNT];
        logic [LEN_W-1:0] new_len[SYMBOL_COUNT];
        bit bits[$];
        logic [7:0] b;
        logic [TARGET_W-1:0] tgt;

        leaves = '{1, 1};
        repeat ($urandom_range(0, 20))
        begin
            pick = $urandom_range(0, leaves.size() - 1);
            l = leaves[pick];
            if (l < MAX_LEN)
            begin
                leaves[pick] = l + 1;
                leaves.insert(leaves.size(), l + 1);
            end
        end
        foreach (new_len[i]) new_len[i] = '0;
        foreach (leaves[i])
        begin
            do pick = $urandom_range(0, SYMBOL_COUNT - 1); while (new_len[pick] != 0);
            new_len[pick] = LEN_W'(leaves[i]);
            syms.insert(syms.size(), pick);
        end
        if ($urandom_range(0, 3) == 0)
            new_len[syms.pop_back()] = '0;

        foreach (cnt[i]) cnt[i] = 0;
        foreach (new_len[s]) if (new_len[s] != 0) cnt[new_len[s]]++;
        next_code[0] = 0;
        for (int k = 1; k < LEN_SLOTS; k++)
            next_code[k] = (next_code[k-1] + cnt[k-1]) << 1;
        for (int s = 0; s < SYMBOL_COUNT; s++)
            if (new_len[s] != 0)
            begin
                codes[s] = next_code[new_len[s]];
                next_code[new_len[s]]++;
            end

        nsym = $urandom_range(1, 24);
        repeat (nsym)
        begin
            pick = syms[$urandom_range(0, syms.size() - 1)];
            for (int k = new_len[pick] - 1; k >= 0; k--)
                bits.insert(bits.size(), codes[pick][k]);
        end
        while (bits.size() % 8 != 0) bits.insert(bits.size(), 1'($urandom_range(0, 1)));

        mode = $urandom_range(0, 9);
        tgt = nsym;
        if (mode == 7)
            tgt = nsym + $urandom_range(1, 4);
        set_target(tgt);

        for (int s = 0; s < SYMBOL_COUNT; s++)
            if (cur_len[s] != 0 && new_len[s] == 0)
                send(OP_LOAD, SYM_W'(s), '0, SYM_W'($urandom));
        syms.shuffle();
        for (int s = 0; s < SYMBOL_COUNT; s++)
            if (new_len[s] != 0)
                send(OP_LOAD, SYM_W'(s), new_len[s], SYM_W'($urandom));
        send(OP_FINISH, SYM_W'($urandom), LEN_W'($urandom), SYM_W'($urandom));

        if (mode == 5 && !calm)
            hold_cycles = 300;
        while (bits.size() > 0)
        begin
            for (int k = 7; k >= 0; k--) b[k] = bits.pop_front();
            if (mode == 6 && bits.size() == 0)
                break;
            if (mode == 9 && $urandom_range(0, 3) == 0)
                b = SYM_W'($urandom);
            send(OP_BYTE, SYM_W'($urandom), LEN_W'($urandom), b);
        end
        if (mode == 8)
            send(OP_BYTE, SYM_W'($urandom), LEN_W'($urandom), SYM_W'($urandom));
        send(OP_END, SYM_W'($urandom), LEN_W'($urandom), SYM_W'($urandom));
    endtask

    initial
    begin
        sb.clear();
        foreach (cur_len[i]) cur_len[i] = '0;
        item_bus.valid = 1'b0;
        item_bus.opcode = OP_LOAD;
        item_bus.symbol_index = '0;
        item_bus.code_length = '0;
        item_bus.data_byte = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_target(32'd5);
        send(OP_BYTE, 8'h00, 4'h0, 8'hA5);
        send(OP_END, 8'h00, 4'h0, 8'h00);
        send(OP_BYTE, 8'h00, 4'h0, 8'h3C);

        set_target(32'd0);
        send(OP_FINISH, 8'h00, 4'h0, 8'h00);
        send(OP_BYTE, 8'h00, 4'h0, 8'hFF);
        send(OP_END, 8'h00, 4'h0, 8'h00);
        send(OP_FINISH, 8'h00, 4'h0, 8'h00);
        send(OP_END, 8'h00, 4'h0, 8'h00);

        set_target(32'hFFFF_FFFF);
        for (int s = 0; s < 14; s++)
            send(OP_LOAD, SYM_W'(s), LEN_W'(s + 1), 8'h00);
        send(OP_LOAD, 8'd254, 4'd15, 8'h00);
        send(OP_LOAD, 8'd255, 4'd15, 8'h00);
        send(OP_FINISH, 8'h00, 4'h0, 8'h00);
        hold_cycles = 200;
        send(OP_BYTE, 8'h00, 4'h0, 8'h00);
        send(OP_BYTE, 8'h00, 4'h0, 8'hFF);
        send(OP_BYTE, 8'h00, 4'h0, 8'hFF);
        send(OP_BYTE, 8'h00, 4'h0, 8'h7F);
        send(OP_END, 8'h00, 4'h0, 8'h00);

        while (items_sent < ITEM_GOAL)
        begin
            if (items_sent > ITEM_GOAL - 70)
                calm = 1'b1;
            random_phase();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** canonical_huffman_decoder: PASSED **");
        else
            $display("** canonical_huffman_decoder: FAILED **");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/chd_pkg.sv
design/chd_item_if.sv
design/chd_result_if.sv
design/chd_datapath.sv
design/chd_ctrl.sv
design/canonical_huffman_decoder.sv
tb/sv/canonical_huffman_decoder_test.sv
